FILE: rtl/dmf_pkg.sv
`default_nettype none
package dmf_pkg;

	localparam int MSG_MAX     = 32;
	localparam int IDX_W       = $clog2(MSG_MAX);
	localparam int ADDR_W      = IDX_W + 1;
	localparam int STORE_DEPTH = 2 ** ADDR_W;

	localparam logic [7:0]       DELIM_CHAR   = 8'h24;
	localparam logic [7:0]       NEWLINE_CHAR = 8'h0A;
	localparam logic [15:0]      COUNT_MAX    = 16'hFFFF;
	localparam logic [15:0]      STORE_LAST   = 16'(MSG_MAX - 1);
	localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(MSG_MAX - 1);
	localparam logic [IDX_W-1:0] IDX_FIRST    = IDX_W'(1);

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_error;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_last;
		logic [15:0] msg_length;
	} out_item_t;

	typedef struct packed {
		logic             bank;
		logic [IDX_W-1:0] stored;
		logic [15:0]      length;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

endpackage
`default_nettype wire

FILE: rtl/delimiter_message_framer_unit.sv
`default_nettype none
// Frames '$'-delimited messages from a byte stream. The input side takes one byte per cycle
// while fewer than two closed messages are queued or in readout; payload goes into a two-bank
// message store, so one message can be collected while the previous one is read out. full
// rises only while both banks are held. Readout runs from the store's single read port at one
// result per cycle: for each message it takes the command, then issues '$', the payload and a newline,
// slowed only by pop back-pressure on the four-entry result queue.
module delimiter_message_framer_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire dmf_pkg::in_item_t   in_item,
	output logic                     empty,
	input  wire logic                pop,
	output dmf_pkg::out_item_t       out_item
);
	import dmf_pkg::*;

	ram_wr_t    ram_wr;
	ram_rd_t    ram_rd;
	logic [7:0] rd_data;
	logic       cmd_push, cmd_avail, cmd_pop, done;
	cmd_t       cmd_in, cmd_out;

	dmf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.ram_wr   (ram_wr),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.done     (done)
	);

	dmf_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.cmd_in  (cmd_in),
		.avail   (cmd_avail),
		.pop     (cmd_pop),
		.cmd_out (cmd_out)
	);

	dmf_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr.en),
		.wr_addr (ram_wr.addr),
		.wr_data (ram_wr.data),
		.rd_en   (ram_rd.en),
		.rd_addr (ram_rd.addr),
		.rd_data (rd_data)
	);

	dmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_avail),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.rd        (ram_rd),
		.rd_data   (rd_data),
		.done      (done),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

FILE: rtl/dmf_ram.sv
`default_nettype none
module dmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dmf_front.sv
`default_nettype none
module dmf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire dmf_pkg::in_item_t  in_item,
	output dmf_pkg::ram_wr_t        ram_wr,
	output logic                    cmd_push,
	output dmf_pkg::cmd_t           cmd,
	input  wire logic               done
);
	import dmf_pkg::*;

	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_OPEN = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;

	logic [1:0]  phase_q, phase_d;
	logic [15:0] count_q, count_d, count_inc;
	logic        bad_q, bad_d;
	logic        bank_q, bank_d;
	logic [1:0]  outstanding_q, outstanding_d;
	logic        accept, is_delim;

	assign full      = (outstanding_q == 2'd2);
	assign accept    = push && !full;
	assign is_delim  = (in_item.rx_byte == DELIM_CHAR);
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 16'd1;

	assign cmd.bank   = bank_q;
	assign cmd.stored = (count_q > STORE_LAST) ? IDX_LAST : count_q[IDX_W-1:0];
	assign cmd.length = count_q;

	always_comb begin
		phase_d      = phase_q;
		count_d      = count_q;
		bad_d        = bad_q;
		bank_d       = bank_q;
		cmd_push     = 1'b0;
		ram_wr.en    = 1'b0;
		ram_wr.addr  = {bank_q, count_inc[IDX_W-1:0]};
		ram_wr.data  = in_item.rx_byte;
		if (accept && in_item.rx_error) begin
			bad_d = 1'b1;
		end else if (accept) begin
			unique case (phase_q)
				PH_OPEN: begin
					if (is_delim) begin
						count_d = '0;
						bad_d   = 1'b0;
					end else begin
						phase_d     = PH_DATA;
						count_d     = 16'd1;
						ram_wr.en   = 1'b1;
						ram_wr.addr = {bank_q, IDX_FIRST};
					end
				end
				PH_DATA: begin
					if (is_delim) begin
						if (!bad_q) begin
							cmd_push = 1'b1;
							bank_d   = !bank_q;
						end
						phase_d = PH_OPEN;
						count_d = '0;
						bad_d   = 1'b0;
					end else begin
						count_d   = count_inc;
						ram_wr.en = (count_inc <= STORE_LAST);
					end
				end
				default: begin
					if (is_delim) begin
						phase_d = PH_OPEN;
						count_d = '0;
						bad_d   = 1'b0;
					end
				end
			endcase
		end
	end

	always_comb begin
		outstanding_d = outstanding_q;
		if (cmd_push && !done) begin
			outstanding_d = outstanding_q + 2'd1;
		end else if (!cmd_push && done) begin
			outstanding_d = outstanding_q - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			count_q       <= '0;
			bad_q         <= 1'b0;
			bank_q        <= 1'b0;
			outstanding_q <= '0;
		end else begin
			phase_q       <= phase_d;
			count_q       <= count_d;
			bad_q         <= bad_d;
			bank_q        <= bank_d;
			outstanding_q <= outstanding_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_dispatch_when_banks_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> outstanding_q != 2'd2)
		else $error("message dispatched while both banks held");
	a_no_write_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr.en |-> ram_wr.addr[IDX_W-1:0] != '0)
		else $error("payload written to delimiter slot");
`endif

endmodule
`default_nettype wire

FILE: rtl/dmf_cmd_queue.sv
`default_nettype none
module dmf_cmd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire dmf_pkg::cmd_t  cmd_in,
	output logic                avail,
	input  wire logic           pop,
	output dmf_pkg::cmd_t       cmd_out
);
	import dmf_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign avail   = (cnt_q != 2'd0);
	assign cmd_out = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2) || pop)
		else $error("command queue overflow");
`endif

endmodule
`default_nettype wire

FILE: rtl/dmf_back.sv
`default_nettype none
module dmf_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	input  wire dmf_pkg::cmd_t      cmd,
	output logic                    cmd_pop,
	output dmf_pkg::ram_rd_t        rd,
	input  wire logic [7:0]         rd_data,
	output logic                    done,
	output logic                    empty,
	input  wire logic               pop,
	output dmf_pkg::out_item_t      out_item
);
	import dmf_pkg::*;

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_DELIM = 2'd1;
	localparam logic [1:0] B_DATA  = 2'd2;
	localparam logic [1:0] B_NL    = 2'd3;
	localparam logic [2:0] OUT_DEPTH = 3'd4;

	logic [1:0]       st_q, st_d;
	cmd_t             cur_q;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             can_issue, issue, iss_ram, iss_last;
	logic [7:0]       iss_byte;

	logic             v_s1, ram_s1, last_s1;
	logic [7:0]       byte_s1;
	logic [15:0]      len_s1;

	out_item_t        ent_q [4];
	logic [1:0]       wp_q, rp_q;
	logic [2:0]       cnt_q;
	logic             pop_f;
	out_item_t        push_item;

	assign can_issue = (cnt_q + {2'b00, v_s1}) < OUT_DEPTH;

	always_comb begin
		st_d     = st_q;
		idx_d    = idx_q;
		issue    = 1'b0;
		iss_ram  = 1'b0;
		iss_last = 1'b0;
		iss_byte = DELIM_CHAR;
		cmd_pop  = 1'b0;
		done     = 1'b0;
		rd.en    = 1'b0;
		rd.addr  = {cur_q.bank, idx_q};
		unique case (st_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					st_d    = B_DELIM;
				end
			end
			B_DELIM: begin
				if (can_issue) begin
					issue = 1'b1;
					idx_d = IDX_FIRST;
					st_d  = B_DATA;
				end
			end
			B_DATA: begin
				if (can_issue) begin
					issue   = 1'b1;
					iss_ram = 1'b1;
					rd.en   = 1'b1;
					if (idx_q == cur_q.stored) begin
						st_d = B_NL;
					end else begin
						idx_d = idx_q + IDX_FIRST;
					end
				end
			end
			B_NL: begin
				if (can_issue) begin
					issue    = 1'b1;
					iss_byte = NEWLINE_CHAR;
					iss_last = 1'b1;
					done     = 1'b1;
					st_d     = B_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		idx_q   <= idx_d;
		ram_s1  <= iss_ram;
		last_s1 <= iss_last;
		byte_s1 <= iss_byte;
		len_s1  <= cur_q.length;
	end

	assign push_item.out_byte   = ram_s1 ? rd_data : byte_s1;
	assign push_item.out_last   = last_s1;
	assign push_item.msg_length = len_s1;

	assign empty    = (cnt_q == 3'd0);
	assign pop_f    = pop && !empty;
	assign out_item = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (v_s1) begin
			ent_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_IDLE;
			v_s1  <= 1'b0;
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			v_s1 <= issue;
			if (v_s1) begin
				wp_q <= wp_q + 2'd1;
			end
			if (pop_f) begin
				rp_q <= rp_q + 2'd1;
			end
			if (v_s1 && !pop_f) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (!v_s1 && pop_f) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_out_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OUT_DEPTH)
		else $error("result queue overflow");
	a_last_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1) |-> (byte_s1 == NEWLINE_CHAR) && !ram_s1)
		else $error("last flag on a byte other than newline");
`endif

endmodule
`default_nettype wire
